// File: hw/rtl/bse_pkg.sv
// Shared types and constants of the bubble sort engine.
package bse_pkg;

  localparam int MAX_ITEMS  = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(MAX_ITEMS);
  localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]          idx_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;

  typedef struct packed {
    value_t value;
    logic   final_item;
  } item_t;

  typedef struct packed {
    value_t sorted_value;
    logic   final_result;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // incoming request, store if room
    logic count_clr;   // set fully delivered
    logic rd_en;
    idx_t rd_addr;
    logic carry_init;  // first element of a pass into the carry
    logic step;        // compare carry with read data, write the smaller
    logic flush;       // write carry at end of pass
    idx_t wr_addr;
    logic out_load;    // read data into output register
    logic out_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    cnt_t count;
    logic greater;        // carry > read data
    logic out_full;
    logic out_taken;
    logic out_taken_last;
  } dp_status_t;

endpackage

// File: hw/rtl/bse_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/bse_datapath.sv
// Datapath of the bubble sort engine: element store, carry, comparator, output register.
module bse_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  bse_pkg::dp_cmd_t     cmd,
  output bse_pkg::dp_status_t  status,
  input  bse_pkg::item_t       item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output bse_pkg::result_t     result
);

  bse_pkg::cnt_t   count;
  bse_pkg::value_t carry;
  bse_pkg::value_t rd_data;
  bse_pkg::value_t wdata;
  bse_pkg::idx_t   waddr;
  logic            we;
  logic            room;
  logic            greater;
  logic            taken;

  assign room    = count < bse_pkg::cnt_t'(bse_pkg::MAX_ITEMS);
  assign greater = carry > rd_data;
  assign taken   = result_valid && !result_stall;

  always_comb begin
    we    = 1'b0;
    waddr = cmd.wr_addr;
    wdata = carry;
    if (cmd.load) begin
      we    = room;
      waddr = count[bse_pkg::IDX_BITS-1:0];
      wdata = item.value;
    end else if (cmd.step) begin
      we    = 1'b1;
      wdata = greater ? rd_data : carry;
    end else if (cmd.flush) begin
      we    = 1'b1;
    end
  end

  bse_ram #(
    .WIDTH(bse_pkg::VALUE_BITS),
    .DEPTH(bse_pkg::MAX_ITEMS)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(cmd.rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_clr) begin
      count <= '0;
    end else if (cmd.load && room) begin
      count <= count + bse_pkg::cnt_t'(1);
    end
  end

  // larger element travels up the pass
  always_ff @(posedge clk) begin
    if (cmd.carry_init) begin
      carry <= rd_data;
    end else if (cmd.step && !greater) begin
      carry <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (taken) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.sorted_value <= rd_data;
      result.final_result <= cmd.out_last;
    end
  end

  assign status.count          = count;
  assign status.greater        = greater;
  assign status.out_full       = result_valid;
  assign status.out_taken      = taken;
  assign status.out_taken_last = taken && result.final_result;

endmodule

// File: hw/rtl/bse_ctrl.sv
// Controller of the bubble sort engine: load, sort passes and output sequencing.
module bse_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_final,
  output logic                item_stall,
  input  bse_pkg::dp_status_t status,
  output bse_pkg::dp_cmd_t    cmd
);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_SETUP  = 3'd1;
  localparam logic [2:0] S_PSTART = 3'd2;
  localparam logic [2:0] S_PFIRST = 3'd3;
  localparam logic [2:0] S_PSTEP  = 3'd4;
  localparam logic [2:0] S_PFLUSH = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0]    state, state_next;
  bse_pkg::cnt_t limit, limit_next;      // elements in the current pass
  bse_pkg::idx_t j, j_next;              // index of the element arriving
  logic          swapped, swapped_next;
  bse_pkg::cnt_t rk, rk_next;            // next output read
  logic          pending, pending_next;  // output read in flight
  logic          pend_last, pend_last_next;
  bse_pkg::cnt_t last_idx;
  logic          accept;
  logic          issue;

  assign item_stall = (state != S_LOAD);
  assign accept     = item_valid && (state == S_LOAD);
  assign last_idx   = limit - bse_pkg::cnt_t'(1);
  assign issue      = !pending && (!status.out_full || status.out_taken) && (rk < status.count);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    limit_next     = limit;
    j_next         = j;
    swapped_next   = swapped;
    rk_next        = rk;
    pending_next   = pending;
    pend_last_next = pend_last;
    unique case (state)
      S_LOAD: begin
        cmd.load = accept;
        if (accept && item_final) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        limit_next   = status.count;
        rk_next      = '0;
        pending_next = 1'b0;
        state_next   = (status.count < bse_pkg::cnt_t'(2)) ? S_OUT : S_PSTART;
      end
      S_PSTART: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = '0;
        j_next      = bse_pkg::idx_t'(1);
        state_next  = S_PFIRST;
      end
      S_PFIRST: begin
        cmd.carry_init = 1'b1;
        cmd.rd_en      = 1'b1;
        cmd.rd_addr    = j;
        swapped_next   = 1'b0;
        state_next     = S_PSTEP;
      end
      S_PSTEP: begin
        cmd.step    = 1'b1;
        cmd.wr_addr = j - bse_pkg::idx_t'(1);
        if (status.greater) begin
          swapped_next = 1'b1;
        end
        if (bse_pkg::cnt_t'(j) + bse_pkg::cnt_t'(1) < limit) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = j + bse_pkg::idx_t'(1);
          j_next      = j + bse_pkg::idx_t'(1);
        end else begin
          state_next = S_PFLUSH;
        end
      end
      S_PFLUSH: begin
        cmd.flush   = 1'b1;
        cmd.wr_addr = last_idx[bse_pkg::IDX_BITS-1:0];
        if (!swapped || limit == bse_pkg::cnt_t'(2)) begin
          state_next = S_OUT;
        end else begin
          limit_next = last_idx;
          state_next = S_PSTART;
        end
      end
      S_OUT: begin
        if (pending) begin
          cmd.out_load = 1'b1;
          cmd.out_last = pend_last;
          pending_next = 1'b0;
        end
        if (issue) begin
          cmd.rd_en      = 1'b1;
          cmd.rd_addr    = rk[bse_pkg::IDX_BITS-1:0];
          pending_next   = 1'b1;
          pend_last_next = (rk == status.count - bse_pkg::cnt_t'(1));
          rk_next        = rk + bse_pkg::cnt_t'(1);
        end
        if (status.out_taken_last) begin
          cmd.count_clr = 1'b1;
          state_next    = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

  always_ff @(posedge clk) begin
    limit     <= limit_next;
    j         <= j_next;
    swapped   <= swapped_next;
    rk        <= rk_next;
    pend_last <= pend_last_next;
  end

endmodule

// File: hw/rtl/bubble_sort_engine.sv
// Top level of the bubble sort engine.
// Collects up to 16 signed 32-bit values, one request per cycle while loading, and on the
// request marked final_item sorts them ascending (stable bubble sort that stops
// after a pass without a swap) and sends them out, final_result set on the
// last one. Requests beyond 16 are dropped, but a final mark on one still
// starts the sort. Input is stalled from the final request until the last
// result is taken. For a set of n stored values: the values are loaded, a
// setup step follows, then passes over L elements run (L = n, n-1, ... down
// to 2, fewer on early exit); each result is then read from the store into
// the output register, and the next read starts only once the last has landed.
// Speed is bounded by the store: one read port and one write port, one
// compare per cycle, and a registered read before each result.
module bubble_sort_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  bse_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output bse_pkg::result_t result
);

  bse_pkg::dp_cmd_t    cmd;
  bse_pkg::dp_status_t status;

  // sequencing: load, passes, output
  bse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_final(item.final_item),
    .item_stall(item_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // store, carry compare, output register
  bse_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // no results pending while requests are taken
  a_load_no_output: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> !result_valid)
    else $error("result pending while loading");

  // output register is empty whenever a read lands in it
  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !result_valid)
    else $error("output register overwritten");

  // a sort step never reads the entry it writes
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_en && (cmd.step || cmd.flush)) |-> (cmd.rd_addr != cmd.wr_addr))
    else $error("store read and write at the same address");

  // store never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (status.count <= bse_pkg::cnt_t'(bse_pkg::MAX_ITEMS)))
    else $error("store count overflow");

endmodule

// File: bench/bubble_sort_engine_checker.sv
// Checker for the bubble sort engine: tracks the stored set and checks the sorted results.
module bubble_sort_engine_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_stall,
  input  bse_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_stall,
  input  bse_pkg::result_t result,
  output int               fail_count,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the element store and its fill level.
  bse_pkg::value_t  shadow_store [bse_pkg::MAX_ITEMS];
  int               shadow_count;
  bse_pkg::result_t sorted_q [$];

  bse_pkg::result_t want;
  bse_pkg::value_t  swap_tmp;
  bit               swapped;

  always @(posedge clk) begin
    if (rst) begin
      shadow_count = 0;
      sorted_q.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (sorted_q.size() == 0) begin
          $error("unexpected result: sorted_value %0d final_result %0b",
                 result.sorted_value, result.final_result);
          fail_count++;
        end else begin
          want = sorted_q.pop_front();
          if (result.sorted_value !== want.sorted_value) begin
            $error("sorted_value: expected %0d, actual %0d",
                   want.sorted_value, result.sorted_value);
            fail_count++;
          end
          if (result.final_result !== want.final_result) begin
            $error("final_result: expected %0b, actual %0b",
                   want.final_result, result.final_result);
            fail_count++;
          end
        end
      end

      if (item_valid && !item_stall) begin
        // full store drops the value, final mark still triggers the sort
        if (shadow_count < bse_pkg::MAX_ITEMS) begin
          shadow_store[shadow_count] = item.value;
          shadow_count++;
        end
        if (item.final_item) begin
          // bubble sort, stop after a clean pass; equal values never swap
          for (int pass = 0; pass < shadow_count - 1; pass++) begin
            swapped = 1'b0;
            for (int k = 0; k + 1 < shadow_count - pass; k++) begin
              if (shadow_store[k] > shadow_store[k+1]) begin
                swap_tmp          = shadow_store[k];
                shadow_store[k]   = shadow_store[k+1];
                shadow_store[k+1] = swap_tmp;
                swapped           = 1'b1;
              end
            end
            if (!swapped) break;
          end
          for (int k = 0; k < shadow_count; k++) begin
            want.sorted_value = shadow_store[k];
            want.final_result = (k == shadow_count - 1);
            sorted_q.push_back(want);
          end
          shadow_count = 0;
        end
      end
    end
    outstanding <= sorted_q.size();
  end

endmodule

// File: bench/bubble_sort_engine_tb.sv
// Testbench top for the bubble sort engine: stimulus, receiver stalls and verdict.
module bubble_sort_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bse_pkg::value_t VALUE_MAX = {1'b0, {(bse_pkg::VALUE_BITS-1){1'b1}}};
  localparam bse_pkg::value_t VALUE_MIN = {1'b1, {(bse_pkg::VALUE_BITS-1){1'b0}}};
  localparam int     HOLD_OFF_CYCLES = 300;
  localparam int     DRAIN_CYCLES    = 60;
  localparam int     CYCLE_LIMIT     = 200000;

  // Content patterns for a random set.
  typedef enum int {
    SHAPE_SPREAD,
    SHAPE_RISING,
    SHAPE_FALLING,
    SHAPE_REPEATS,
    SHAPE_EXTREMES
  } set_shape_e;

  logic             clk;
  logic             rst;
  logic             item_valid;
  logic             item_stall;
  bse_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  bse_pkg::result_t result;

  int               fail_count;
  int               outstanding;
  int               requests_sent;
  int               cycle_count;
  bit               gaps_on;
  bit               calm;
  bit               hold_off_req;
  bit               hold_off_done;
  bse_pkg::value_t  set_buf [$];

  bubble_sort_engine dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  bubble_sort_engine_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // One request; an optional idle burst goes ahead of it. Returns at the
  // edge where the request is taken, so valid can stay high into the next.
  task automatic send_request(input bse_pkg::value_t v, input logic last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{value: v, final_item: last};
    do @(posedge clk); while (item_stall);
    requests_sent++;
  endtask

  // Sends the whole buffered set, final mark on its last value.
  task automatic send_set();
    for (int k = 0; k < set_buf.size(); k++) begin
      send_request(set_buf[k], k == set_buf.size() - 1);
    end
    set_buf.delete();
  endtask

  function automatic void fill_set(input int n, input set_shape_e shape);
    bse_pkg::value_t base;
    bse_pkg::value_t other;
    int              stride;
    base   = bse_pkg::value_t'($urandom_range(0, 4000)) - 2000;
    other  = bse_pkg::value_t'($urandom);
    stride = $urandom_range(0, 50);  // zero stride gives an all-equal run
    for (int k = 0; k < n; k++) begin
      case (shape)
        SHAPE_SPREAD:   set_buf.push_back(bse_pkg::value_t'($urandom));
        SHAPE_RISING:   set_buf.push_back(base + bse_pkg::value_t'(k * stride));
        SHAPE_FALLING:  set_buf.push_back(base - bse_pkg::value_t'(k * stride));
        SHAPE_REPEATS:  set_buf.push_back($urandom_range(0, 1) ? base : other);
        SHAPE_EXTREMES: begin
          case ($urandom_range(0, 4))
            0:       set_buf.push_back(VALUE_MIN);
            1:       set_buf.push_back(VALUE_MAX);
            2:       set_buf.push_back(-1);
            3:       set_buf.push_back(0);
            default: set_buf.push_back(1);
          endcase
        end
        default: set_buf.push_back(0);
      endcase
    end
  endfunction

  // Mostly sets that fit; now and then one that overruns the store.
  task automatic random_set();
    int n;
    n = ($urandom_range(0, 7) == 0)
        ? $urandom_range(bse_pkg::MAX_ITEMS + 1, bse_pkg::MAX_ITEMS + 4)
        : $urandom_range(1, bse_pkg::MAX_ITEMS);
    fill_set(n, set_shape_e'($urandom_range(0, 4)));
    send_set();
  endtask

  // Block until every predicted result has been taken. The checker's count
  // is registered, so always step first.
  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: short random stall bursts, plus one long hold-off on request
  // from the stimulus so the engine backs up and stalls its input.
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        hold_off_done = 1'b1;
        result_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst           <= 1'b1;
    item_valid    <= 1'b0;
    item          <= '0;
    hold_off_req  <= 1'b0;
    requests_sent = 0;
    gaps_on       = 1'b1;
    calm          = 1'b0;
    hold_off_done = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-element set
    set_buf.push_back(VALUE_MAX);
    send_set();
    // two extremes in reverse order
    set_buf.push_back(VALUE_MAX);
    set_buf.push_back(VALUE_MIN);
    send_set();
    // equal values around zero, sign must decide the order
    set_buf.push_back(-1);
    set_buf.push_back(0);
    set_buf.push_back(-1);
    send_set();
    // full store in falling order, then a final request that gets dropped
    for (int k = 0; k < bse_pkg::MAX_ITEMS; k++) begin
      set_buf.push_back(k == 0 ? VALUE_MAX
                               : bse_pkg::value_t'((bse_pkg::MAX_ITEMS - 1 - k) * 1000 - 7000));
    end
    set_buf.push_back(VALUE_MIN);
    send_set();

    while (requests_sent < 90) random_set();

    // Receiver holds off while a full set and then two random sets come; input must back up.
    hold_off_req <= 1'b1;
    fill_set(bse_pkg::MAX_ITEMS, SHAPE_SPREAD);
    send_set();
    random_set();
    random_set();
    // sender pauses until the engine has fully emptied
    item_valid <= 1'b0;
    wait_drained();

    while (requests_sent < 170) random_set();

    // last stretch runs with no idling on either side
    gaps_on = 1'b0;
    calm    = 1'b1;
    while (requests_sent < 210) random_set();
    item_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: bubble_sort_engine.f
hw/rtl/bse_pkg.sv
hw/rtl/bse_ram.sv
hw/rtl/bse_datapath.sv
hw/rtl/bse_ctrl.sv
hw/rtl/bubble_sort_engine.sv
bench/bubble_sort_engine_checker.sv
bench/bubble_sort_engine_tb.sv
